// ===== src/kls_pkg.sv =====
// Shared types and constants for the k-th largest selection block.
package kls_pkg;

  localparam int DATA_W = 32;
  localparam int RANK_W = 5;

  // Link between neighboring list cells
  typedef struct packed {
    logic              valid;  // cell holds an entry
    logic              ins;    // new sample goes at or ahead of this cell
    logic [DATA_W-1:0] value;  // stored entry
  } kls_link_t;

endpackage

// ===== src/kls_cell.sv =====
// One slot of the descending top-k list; compares the broadcast sample and shifts down.
module kls_cell
  import kls_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              clear,
  input  logic [DATA_W-1:0] sample,
  input  kls_link_t         prev,
  output kls_link_t         cur,
  output logic              nxt_valid,
  output logic [DATA_W-1:0] nxt_value
);

  logic              valid_r;
  logic [DATA_W-1:0] value_r;
  logic              ins;

  // equal values go ahead of the stored entry
  assign ins = !valid_r || ($signed(sample) >= $signed(value_r));

  assign nxt_value = ins ? (prev.ins ? prev.value : sample) : value_r;
  assign nxt_valid = valid_r | prev.valid;

  assign cur.valid = valid_r;
  assign cur.ins   = ins;
  assign cur.value = value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= clear ? 1'b0 : nxt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r <= nxt_value;
    end
  end

endmodule

// ===== src/kth_largest_select.sv =====
// Top level: k-th largest value of a set of signed samples, via an insertion cell chain.
// The result is registered and appears in out_tdata in the cycle after the transfer that carries tlast.
// Throughput: one sample per cycle; every cell compares the sample and shifts in parallel.
// Input stalls only while a result waits in the output register and out_tready is low.
// Reset (rst_n low, synchronous): list emptied, output register empty, rank set to 1.
module kth_largest_select
  import kls_pkg::*;
#(
  parameter int MAX_RANK = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [RANK_W-1:0] cfg_wr_data,   // rank_wanted
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,      // [31:0] sample_value
  input  logic              in_tlast,      // end_of_set
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,     // [31:0] kth_value
  output logic              out_tuser      // [0] too_few
);

  localparam int IDX_W = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

  logic [RANK_W-1:0] rank_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_few_r, out_few_nxt;
  logic              in_xfer;
  logic              end_xfer;

  kls_link_t         link [MAX_RANK+1];
  logic              nxt_valid [MAX_RANK];
  logic [DATA_W-1:0] nxt_value [MAX_RANK];
  logic [MAX_RANK-1:0] valid_vec;

  logic [RANK_W-1:0] rank_eff;
  logic [IDX_W-1:0]  rank_idx;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign end_xfer  = in_xfer && in_tlast;

  // head of chain: always valid, never shifts a value in
  assign link[0].valid = 1'b1;
  assign link[0].ins   = 1'b0;
  assign link[0].value = '0;

  for (genvar i = 0; i < MAX_RANK; i++) begin : g_cell
    kls_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .load      (in_xfer),
      .clear     (in_tlast),
      .sample    (in_tdata),
      .prev      (link[i]),
      .cur       (link[i+1]),
      .nxt_valid (nxt_valid[i]),
      .nxt_value (nxt_value[i])
    );
    assign valid_vec[i] = link[i+1].valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= RANK_W'(1);
    end else if (cfg_wr_en) begin
      rank_r <= cfg_wr_data;
    end
  end

  // clamp rank to 1..MAX_RANK
  always_comb begin
    rank_eff = rank_r;
    if (rank_eff == '0) begin
      rank_eff = RANK_W'(1);
    end
    if (int'(rank_eff) > MAX_RANK) begin
      rank_eff = RANK_W'(MAX_RANK);
    end
    rank_idx = IDX_W'(int'(rank_eff) - 1);
  end

  // read the k-th slot as it stands after this sample goes in
  always_comb begin
    out_few_nxt  = !nxt_valid[rank_idx];
    out_data_nxt = out_few_nxt ? '0 : nxt_value[rank_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (end_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (end_xfer) begin
      out_data_r <= out_data_nxt;
      out_few_r  <= out_few_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_few_r;

  // filled slots always form a prefix of the chain
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec + MAX_RANK'(1)) & valid_vec) == '0)
    else $error("list valid bits not contiguous");

  a_clear_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    end_xfer |=> valid_vec == '0)
    else $error("list not emptied after end of set");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(end_xfer))
    else $error("result without end-of-set transfer");

  a_few_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tdata == '0)
    else $error("too_few result carries nonzero value");

endmodule
